@@ rtl/core/ipb_pkg.sv @@
// ----------------------------------------------------------------------------
// ipb_pkg
// Types, widths and register codes shared by the pixel blend modules.
// ----------------------------------------------------------------------------
package ipb_pkg;

   localparam int LANES            = 4;
   localparam int MAX_SOURCES      = 4;
   localparam int WEIGHT_FRAC_BITS = 12;

   localparam int CHAN_W   = 8;
   localparam int PIXEL_W  = 3 * CHAN_W;
   localparam int WEIGHT_W = 16;
   localparam int MASK_W   = LANES;
   localparam int COUNT_W  = 3;
   localparam int LANE_W   = $clog2(LANES);
   localparam int PROD_W   = WEIGHT_W + CHAN_W;
   localparam int SUM_W    = PROD_W + LANE_W;
   localparam int TOTAL_W  = WEIGHT_W + LANE_W;
   localparam int QUOT_W   = CHAN_W;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   localparam int USED_CAP_INT = (MAX_SOURCES < LANES) ? MAX_SOURCES : LANES;
   localparam logic [COUNT_W-1:0]  USED_CAP       = COUNT_W'(USED_CAP_INT);
   localparam logic [COUNT_W-1:0]  ACTIVE_RESET   = COUNT_W'(4);
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET   = WEIGHT_W'(64'd1 << WEIGHT_FRAC_BITS);

   typedef enum logic [2:0] {
      REG_ACTIVE_COUNT = 3'd0,
      REG_WEIGHT_0     = 3'd1,
      REG_WEIGHT_1     = 3'd2,
      REG_WEIGHT_2     = 3'd3,
      REG_WEIGHT_3     = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [PROD_W-1:0]   prod_r;
      logic [PROD_W-1:0]   prod_g;
      logic [PROD_W-1:0]   prod_b;
      logic [WEIGHT_W-1:0] weight;
      logic                contrib;
   } lane_type;

   typedef struct packed {
      logic [SUM_W-1:0]   sum_r;
      logic [SUM_W-1:0]   sum_g;
      logic [SUM_W-1:0]   sum_b;
      logic [TOTAL_W-1:0] total;
      logic               is_null;
   } merge_type;

   typedef struct packed {
      logic [SUM_W-1:0]   rem_r;
      logic [SUM_W-1:0]   rem_g;
      logic [SUM_W-1:0]   rem_b;
      logic [TOTAL_W-1:0] total;
      logic [QUOT_W-1:0]  quot_r;
      logic [QUOT_W-1:0]  quot_g;
      logic [QUOT_W-1:0]  quot_b;
      logic               is_null;
   } div_type;

endpackage

@@ rtl/core/ipb_if.sv @@
// ----------------------------------------------------------------------------
// ipb_if
// Valid/ready channels for source pixel beats and blended pixel beats.
// ----------------------------------------------------------------------------
interface ipb_req_if;
   logic                         valid;
   logic                         ready;
   logic [ipb_pkg::PIXEL_W-1:0]  pixel_0;
   logic [ipb_pkg::PIXEL_W-1:0]  pixel_1;
   logic [ipb_pkg::PIXEL_W-1:0]  pixel_2;
   logic [ipb_pkg::PIXEL_W-1:0]  pixel_3;
   logic [ipb_pkg::MASK_W-1:0]   null_mask;

   modport source (output valid, pixel_0, pixel_1, pixel_2, pixel_3, null_mask,
                   input ready);
   modport sink   (input valid, pixel_0, pixel_1, pixel_2, pixel_3, null_mask,
                   output ready);
endinterface

interface ipb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ipb_pkg::CHAN_W-1:0]  red;
   logic [ipb_pkg::CHAN_W-1:0]  green;
   logic [ipb_pkg::CHAN_W-1:0]  blue;
   logic                        is_null;

   modport source (output valid, red, green, blue, is_null, input ready);
   modport sink   (input valid, red, green, blue, is_null, output ready);
endinterface

@@ rtl/core/ipb_lane.sv @@
// ----------------------------------------------------------------------------
// ipb_lane
// One source lane: weight (zero when inactive or null) times each color channel, registered.
// ----------------------------------------------------------------------------
module ipb_lane (
   input  logic                          clock,
   input  logic                          enable,
   input  logic                          active,
   input  logic                          null_bit,
   input  logic [ipb_pkg::PIXEL_W-1:0]   pixel,
   input  logic [ipb_pkg::WEIGHT_W-1:0]  weight,
   output ipb_pkg::lane_type             lane_out
);

   logic                         contrib;
   logic [ipb_pkg::WEIGHT_W-1:0] weight_eff;
   ipb_pkg::lane_type            lane_ff;
   ipb_pkg::lane_type            lane_in;

   always_comb begin
      contrib    = active && !null_bit;
      weight_eff = contrib ? weight : '0;
      lane_in.prod_r  = ipb_pkg::PROD_W'(weight_eff) *
                        ipb_pkg::PROD_W'(pixel[3*ipb_pkg::CHAN_W-1:2*ipb_pkg::CHAN_W]);
      lane_in.prod_g  = ipb_pkg::PROD_W'(weight_eff) *
                        ipb_pkg::PROD_W'(pixel[2*ipb_pkg::CHAN_W-1:ipb_pkg::CHAN_W]);
      lane_in.prod_b  = ipb_pkg::PROD_W'(weight_eff) *
                        ipb_pkg::PROD_W'(pixel[ipb_pkg::CHAN_W-1:0]);
      lane_in.weight  = weight_eff;
      lane_in.contrib = contrib;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_out = lane_ff;

endmodule

@@ rtl/core/ipb_merge.sv @@
// ----------------------------------------------------------------------------
// ipb_merge
// Sum the lane products and weights, flag a beat with no contribution or zero total weight.
// ----------------------------------------------------------------------------
module ipb_merge (
   input  logic                                    clock,
   input  logic                                    enable,
   input  ipb_pkg::lane_type [ipb_pkg::LANES-1:0]  lanes,
   output ipb_pkg::merge_type                      merge_out
);

   ipb_pkg::merge_type merge_ff;
   ipb_pkg::merge_type merge_in;
   logic               any;

   always_comb begin
      merge_in = '0;
      any      = 1'b0;
      for (int i = 0; i < ipb_pkg::LANES; i++) begin
         merge_in.sum_r = merge_in.sum_r + ipb_pkg::SUM_W'(lanes[i].prod_r);
         merge_in.sum_g = merge_in.sum_g + ipb_pkg::SUM_W'(lanes[i].prod_g);
         merge_in.sum_b = merge_in.sum_b + ipb_pkg::SUM_W'(lanes[i].prod_b);
         merge_in.total = merge_in.total + ipb_pkg::TOTAL_W'(lanes[i].weight);
         any            = any | lanes[i].contrib;
      end
      merge_in.is_null = !any || (merge_in.total == '0);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         merge_ff <= merge_in;
      end
   end

   assign merge_out = merge_ff;

endmodule

@@ rtl/core/ipb_div.sv @@
// ----------------------------------------------------------------------------
// ipb_div
// Pipelined restoring divider, one quotient bit per stage for all channels.
// ----------------------------------------------------------------------------
module ipb_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  ipb_pkg::merge_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output ipb_pkg::div_type    out_data
);

   localparam int STAGES = ipb_pkg::QUOT_W;

   logic [STAGES-1:0]  valid_ff;
   logic [STAGES-1:0]  valid_in;
   logic [STAGES-1:0]  src_valid;
   logic [STAGES-1:0]  ready_w;
   ipb_pkg::div_type   src      [STAGES];
   ipb_pkg::div_type   stage_in [STAGES];
   ipb_pkg::div_type   stage_ff [STAGES];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      localparam int BIT = STAGES - 1 - k;
      logic [ipb_pkg::SUM_W-1:0] total_sh;

      if (k == 0) begin : g_first
         always_comb begin
            src_valid[k]   = in_valid;
            src[k].rem_r   = in_data.sum_r;
            src[k].rem_g   = in_data.sum_g;
            src[k].rem_b   = in_data.sum_b;
            src[k].total   = in_data.total;
            src[k].quot_r  = '0;
            src[k].quot_g  = '0;
            src[k].quot_b  = '0;
            src[k].is_null = in_data.is_null;
         end
      end else begin : g_next
         always_comb begin
            src_valid[k] = valid_ff[k-1];
            src[k]       = stage_ff[k-1];
         end
      end

      if (k == STAGES - 1) begin : g_last
         assign ready_w[k] = !valid_ff[k] || out_ready;
      end else begin : g_mid
         assign ready_w[k] = !valid_ff[k] || ready_w[k+1];
      end

      always_comb begin
         total_sh    = ipb_pkg::SUM_W'(src[k].total) << BIT;
         stage_in[k] = src[k];
         if (src[k].rem_r >= total_sh) begin
            stage_in[k].rem_r       = src[k].rem_r - total_sh;
            stage_in[k].quot_r[BIT] = !src[k].is_null;
         end
         if (src[k].rem_g >= total_sh) begin
            stage_in[k].rem_g       = src[k].rem_g - total_sh;
            stage_in[k].quot_g[BIT] = !src[k].is_null;
         end
         if (src[k].rem_b >= total_sh) begin
            stage_in[k].rem_b       = src[k].rem_b - total_sh;
            stage_in[k].quot_b[BIT] = !src[k].is_null;
         end
         valid_in[k] = ready_w[k] ? src_valid[k] : valid_ff[k];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_in[k];
         end
      end

      always_ff @(posedge clock) begin
         if (ready_w[k] && src_valid[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign in_ready  = ready_w[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_data  = stage_ff[STAGES-1];

endmodule

@@ rtl/core/inverse_distance_pixel_blend.sv @@
// ----------------------------------------------------------------------------
// inverse_distance_pixel_blend
// Inverse-distance weighted blend of up to four source pixels per beat.
//
// req_ch carries one beat per output pixel: four packed RGB source colors
// and a null mask. rsp_ch returns one blended RGB beat with a null flag for
// every request beat, in order. The csr_ port sets the active source count
// and one Q4.12 weight per source; write it only while the block is idle.
// Four lanes multiply weights by channels, a merge stage sums lanes and
// weights, and an 8-stage pipelined divider forms one quotient bit per stage.
// A beat passes the lane, merge and divider stage registers to rsp_ch; the
// pipeline takes one beat per cycle unless rsp_ch stalls and it fills up.
// Reset empties the pipeline and loads an active count of 4 and weights 1.0.
// When rsp_ch stalls, the beats in flight close up behind the output stage
// and req_ch.ready drops only once every stage holds a beat.
// ----------------------------------------------------------------------------
module inverse_distance_pixel_blend #(
   parameter int MAX_SOURCES      = ipb_pkg::MAX_SOURCES,
   parameter int WEIGHT_FRAC_BITS = ipb_pkg::WEIGHT_FRAC_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   ipb_req_if.sink                          req_ch,
   ipb_rsp_if.source                        rsp_ch,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ipb_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ipb_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ipb_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   localparam int USED_CAP_INT =
      (MAX_SOURCES < ipb_pkg::LANES) ? MAX_SOURCES : ipb_pkg::LANES;
   localparam logic [ipb_pkg::COUNT_W-1:0]  USED_CAP     =
      ipb_pkg::COUNT_W'(USED_CAP_INT);
   localparam logic [ipb_pkg::WEIGHT_W-1:0] WEIGHT_RESET =
      ipb_pkg::WEIGHT_W'(64'd1 << WEIGHT_FRAC_BITS);

   logic [ipb_pkg::COUNT_W-1:0]  active_ff;
   logic [ipb_pkg::WEIGHT_W-1:0] weight_ff [ipb_pkg::LANES];
   logic [ipb_pkg::COUNT_W-1:0]  used_count;
   ipb_pkg::reg_index_type       reg_index;
   logic                         csr_write;

   logic                         valid_a_ff;
   logic                         valid_a_in;
   logic                         valid_b_ff;
   logic                         valid_b_in;
   logic                         enable_a;
   logic                         enable_b;
   logic                         div_ready;

   logic [ipb_pkg::PIXEL_W-1:0]  pixel [ipb_pkg::LANES];
   ipb_pkg::lane_type [ipb_pkg::LANES-1:0] lanes;
   ipb_pkg::merge_type           merged;
   ipb_pkg::div_type             result;

   // Register port
   assign csr_pready = 1'b1;
   assign reg_index  = ipb_pkg::reg_index_type'(csr_paddr[ipb_pkg::CSR_ADDR_W-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ipb_pkg::ACTIVE_RESET;
         for (int i = 0; i < ipb_pkg::LANES; i++) begin
            weight_ff[i] <= WEIGHT_RESET;
         end
      end else if (csr_write) begin
         case (reg_index)
            ipb_pkg::REG_ACTIVE_COUNT: active_ff    <= csr_pwdata[ipb_pkg::COUNT_W-1:0];
            ipb_pkg::REG_WEIGHT_0:     weight_ff[0] <= csr_pwdata[ipb_pkg::WEIGHT_W-1:0];
            ipb_pkg::REG_WEIGHT_1:     weight_ff[1] <= csr_pwdata[ipb_pkg::WEIGHT_W-1:0];
            ipb_pkg::REG_WEIGHT_2:     weight_ff[2] <= csr_pwdata[ipb_pkg::WEIGHT_W-1:0];
            ipb_pkg::REG_WEIGHT_3:     weight_ff[3] <= csr_pwdata[ipb_pkg::WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         ipb_pkg::REG_ACTIVE_COUNT: csr_prdata = ipb_pkg::CSR_DATA_W'(active_ff);
         ipb_pkg::REG_WEIGHT_0:     csr_prdata = ipb_pkg::CSR_DATA_W'(weight_ff[0]);
         ipb_pkg::REG_WEIGHT_1:     csr_prdata = ipb_pkg::CSR_DATA_W'(weight_ff[1]);
         ipb_pkg::REG_WEIGHT_2:     csr_prdata = ipb_pkg::CSR_DATA_W'(weight_ff[2]);
         ipb_pkg::REG_WEIGHT_3:     csr_prdata = ipb_pkg::CSR_DATA_W'(weight_ff[3]);
         default:                   csr_prdata = '0;
      endcase
   end

   // Saturate the source count
   assign used_count = (active_ff > USED_CAP) ? USED_CAP : active_ff;

   // Pipeline control: advance a stage when it is empty or its successor can take the beat
   assign enable_b     = !valid_b_ff || div_ready;
   assign enable_a     = !valid_a_ff || enable_b;
   assign req_ch.ready = enable_a;
   assign valid_a_in   = enable_a ? req_ch.valid : valid_a_ff;
   assign valid_b_in   = enable_b ? valid_a_ff : valid_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_b_in;
      end
   end

   assign pixel[0] = req_ch.pixel_0;
   assign pixel[1] = req_ch.pixel_1;
   assign pixel[2] = req_ch.pixel_2;
   assign pixel[3] = req_ch.pixel_3;

   for (genvar i = 0; i < ipb_pkg::LANES; i++) begin : g_lane
      ipb_lane u_lane (
         .clock    (clock),
         .enable   (enable_a),
         .active   (ipb_pkg::COUNT_W'(i) < used_count),
         .null_bit (req_ch.null_mask[i]),
         .pixel    (pixel[i]),
         .weight   (weight_ff[i]),
         .lane_out (lanes[i])
      );
   end

   ipb_merge u_merge (
      .clock     (clock),
      .enable    (enable_b),
      .lanes     (lanes),
      .merge_out (merged)
   );

   ipb_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_b_ff),
      .in_ready  (div_ready),
      .in_data   (merged),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (result)
   );

   assign rsp_ch.red     = result.quot_r;
   assign rsp_ch.green   = result.quot_g;
   assign rsp_ch.blue    = result.quot_b;
   assign rsp_ch.is_null = result.is_null;

endmodule
